[sv/ffc_pkg.sv]
// ----------------------------------------------------------------------------
// ffc_pkg: shared types, constants and tables of the audio compressor
// Holds the payload structs, the fixed-point constants of the gain path and
// the log2 and exp2 tables, which are built at elaboration time.
// ----------------------------------------------------------------------------
package ffc_pkg;

	localparam int SAMPLE_WIDTH   = 24;
	localparam int DB_TABLE_DEPTH = 256;
	localparam int DB_BITS        = $clog2(DB_TABLE_DEPTH);

	localparam int NORM_W     = 32;
	localparam int LZ_W       = $clog2(NORM_W);
	localparam int NORM_STEPS = LZ_W;
	localparam int STEP_W     = $clog2(NORM_STEPS);
	localparam int NEG_W      = LZ_W + 16;
	localparam int LEVEL_W    = 16;
	localparam int THR_W      = 15;
	localparam int SLOPE_W    = 16;
	localparam int COEF_W     = 17;
	localparam int DIFF_W     = 15;
	localparam int ENV_W      = 22;
	localparam int GR_W       = 14;
	localparam int ATT_W      = 20;
	localparam int SHN_W      = 4;
	localparam int LOG_W      = 16;
	localparam int EXP_W      = 21;

	localparam int MUL_AW = 32;
	localparam int MUL_BW = 30;
	localparam int MUL_PW = 64;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX       = 3'd5;

	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR   = 16'd24576;
	localparam logic [26:0]        DB256_PER_OCT = 27'd101008905;
	localparam logic [29:0]        OCT_PER_DB    = 30'd713378626;
	localparam logic [COEF_W-1:0]  COEF_ONE      = 17'd65536;
	localparam logic [MUL_PW-1:0]  ROUND_LEVEL   = 64'h0000_0000_8000_0000;
	localparam logic [MUL_PW-1:0]  ROUND_Q16     = 64'h0000_0000_0000_8000;
	localparam logic [4:0]         SH_BASE       = 5'd20;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_in;
		logic                           clear_envelope;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_out;
		logic [GR_W-1:0]                gain_reduction_db;
	} result_t;

	typedef struct packed {
		logic                     enable;
		logic signed [THR_W-1:0]  threshold_db;
		logic [SLOPE_W-1:0]       ratio_slope;
		logic [COEF_W-1:0]        attack_coeff;
		logic [COEF_W-1:0]        release_coeff;
		logic [COEF_W-1:0]        mix_amount;
	} cfg_t;

	typedef struct packed {
		logic                done;
		logic                zero;
		logic [LZ_W-1:0]     lz;
		logic [DB_BITS-1:0]  idx;
	} norm_res_t;

	typedef struct packed {
		logic               en;
		logic               acc;
		logic [MUL_AW-1:0]  a;
		logic [MUL_BW-1:0]  b;
		logic [MUL_PW-1:0]  addend;
	} mul_op_t;

	typedef logic [DB_TABLE_DEPTH-1:0][LOG_W-1:0] log_rom_t;
	typedef logic [DB_TABLE_DEPTH-1:0][EXP_W-1:0] exp_rom_t;

	function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
		return (c > COEF_ONE) ? COEF_ONE : c;
	endfunction

	// Bit-serial squaring log2 of x / 2^30 for x in [2^30, 2^31), Q16 truncated.
	function automatic logic [LOG_W-1:0] log2_frac(input logic [63:0] x_in);
		logic [63:0]      x;
		logic [LOG_W-1:0] r;
		x = x_in;
		r = '0;
		for (int k = 0; k < LOG_W; k++) begin
			x = (x * x) >> 30;
			r = {r[LOG_W-2:0], 1'b0};
			if (x >= 64'h0000_0000_8000_0000) begin
				x = x >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic log_rom_t build_log_rom();
		log_rom_t t;
		for (int i = 0; i < DB_TABLE_DEPTH; i++) begin
			t[i] = log2_frac((64'd1 << 30) + (64'(i) << (30 - DB_BITS)));
		end
		return t;
	endfunction

	// Each entry is 2^-f in Q20, found by bisection against the log2 function.
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    t;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [16:0] goal;
		t[0] = 21'h10_0000;
		for (int i = 1; i < DB_TABLE_DEPTH; i++) begin
			goal = 17'(65536 - (i << (16 - DB_BITS)));
			lo = 64'h10_0000;
			hi = 64'h1F_FFFF;
			for (int s = 0; s < 22; s++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if ({1'b0, log2_frac(mid << 10)} <= goal) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			t[i] = EXP_W'((lo + 64'd1) >> 1);
		end
		return t;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();
	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[sv/ffc_mul.sv]
// ----------------------------------------------------------------------------
// ffc_mul: shared multiply-accumulate unit
// One registered multiplier with an adder for rounding constants or for
// accumulating onto the previous product. The product holds when idle.
// ----------------------------------------------------------------------------
module ffc_mul (
	input  logic                         clk,
	input  ffc_pkg::mul_op_t             op,
	output logic [ffc_pkg::MUL_PW-1:0]   prod
);
	import ffc_pkg::*;

	logic [MUL_AW+MUL_BW-1:0] mp;
	logic [MUL_PW-1:0]        prod_q;

	assign mp = op.a * op.b;

	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= MUL_PW'(mp) + (op.acc ? prod_q : op.addend);
		end
	end

	assign prod = prod_q;

endmodule

[sv/ffc_norm.sv]
// ----------------------------------------------------------------------------
// ffc_norm: iterative leading-one normalizer
// Shifts the sample magnitude left in binary steps of 16, 8, 4, 2 and 1 bits,
// one step per cycle, and reports the leading zero count and table index.
// ----------------------------------------------------------------------------
module ffc_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ffc_pkg::SAMPLE_WIDTH-1:0]    mag,
	output ffc_pkg::norm_res_t                  res
);
	import ffc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NORM_W-1:0] norm_q;
	logic [LZ_W-1:0]   lz_q;
	logic [LZ_W-1:0]   sa;
	logic [LZ_W:0]     hi_sh;
	logic              top_zero;

	assign sa       = LZ_W'(1) << (STEP_W'(NORM_STEPS - 1) - step_q);
	assign hi_sh    = (LZ_W + 1)'(NORM_W) - {1'b0, sa};
	assign top_zero = (norm_q >> hi_sh) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(NORM_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			norm_q <= NORM_W'(mag) << (NORM_W - SAMPLE_WIDTH);
			lz_q   <= '0;
		end else if (busy_q && top_zero) begin
			norm_q <= norm_q << sa;
			lz_q   <= lz_q + sa;
		end
	end

	assign res.done = done_q;
	assign res.zero = !norm_q[NORM_W-1];
	assign res.lz   = lz_q;
	assign res.idx  = norm_q[NORM_W-2 -: DB_BITS];

endmodule

[sv/ffc_cfg.sv]
// ----------------------------------------------------------------------------
// ffc_cfg: configuration registers
// Holds the six control registers and presents them with the smoothing and
// mix coefficients saturated at unity.
// ----------------------------------------------------------------------------
module ffc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	output logic                             ready,
	input  logic [ffc_pkg::CFG_IDX_W-1:0]    index,
	input  logic [ffc_pkg::CFG_DATA_W-1:0]   data,
	output ffc_pkg::cfg_t                    cfg
);
	import ffc_pkg::*;

	logic                    enable_q;
	logic signed [THR_W-1:0] threshold_q;
	logic [SLOPE_W-1:0]      slope_q;
	logic [COEF_W-1:0]       attack_q;
	logic [COEF_W-1:0]       release_q;
	logic [COEF_W-1:0]       mix_q;

	assign ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			threshold_q <= -15'sd3072;
			slope_q     <= 16'd49152;
			attack_q    <= COEF_ONE;
			release_q   <= COEF_ONE;
			mix_q       <= COEF_ONE;
		end else if (valid) begin
			unique case (index)
				CFG_ENABLE:    enable_q    <= data[0];
				CFG_THRESHOLD: threshold_q <= data[THR_W-1:0];
				CFG_SLOPE:     slope_q     <= data[SLOPE_W-1:0];
				CFG_ATTACK:    attack_q    <= data[COEF_W-1:0];
				CFG_RELEASE:   release_q   <= data[COEF_W-1:0];
				CFG_MIX:       mix_q       <= data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.enable        = enable_q;
	assign cfg.threshold_db  = threshold_q;
	assign cfg.ratio_slope   = slope_q;
	assign cfg.attack_coeff  = sat_coef(attack_q);
	assign cfg.release_coeff = sat_coef(release_q);
	assign cfg.mix_amount    = sat_coef(mix_q);

endmodule

[sv/feedforward_audio_compressor.sv]
// ----------------------------------------------------------------------------
// feedforward_audio_compressor: log-domain feed-forward compressor
// With enable set, a sample passes the five-step normalizer and then seven
// passes through the one shared multiplier before its result is offered; the
// next sample is taken only after the result enters the output register.
// In bypass the sample goes straight to the finish state and is registered.
// Reset clears the envelope, empties the output register and loads the
// register defaults; enable comes up off.
// ----------------------------------------------------------------------------
module feedforward_audio_compressor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  ffc_pkg::sample_t                 sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ffc_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ffc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ffc_pkg::*;

	localparam int LVL_S_W = LEVEL_W + 2;
	localparam logic [ENV_W-1:0] ENV_MAX = ENV_W'((32'd16384 * 32'd65535) >> 8);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_NORM  = 4'd1;
	localparam logic [3:0] ST_NEG   = 4'd2;
	localparam logic [3:0] ST_LVL   = 4'd3;
	localparam logic [3:0] ST_LEVEL = 4'd4;
	localparam logic [3:0] ST_TGT   = 4'd5;
	localparam logic [3:0] ST_CMP   = 4'd6;
	localparam logic [3:0] ST_ENV   = 4'd7;
	localparam logic [3:0] ST_UPD   = 4'd8;
	localparam logic [3:0] ST_ATT   = 4'd9;
	localparam logic [3:0] ST_EXP   = 4'd10;
	localparam logic [3:0] ST_WET   = 4'd11;
	localparam logic [3:0] ST_WSH   = 4'd12;
	localparam logic [3:0] ST_MIXW  = 4'd13;
	localparam logic [3:0] ST_FIN   = 4'd14;

	cfg_t                       cfg;
	norm_res_t                  nres;
	mul_op_t                    mop;
	logic [MUL_PW-1:0]          prod;

	logic [3:0]                 state_q;
	logic                       res_valid_q;
	result_t                    res_q;
	logic [ENV_W-1:0]           env_q;

	logic [SAMPLE_WIDTH-1:0]    sample_q;
	logic [SAMPLE_WIDTH-1:0]    mag_q;
	logic [SAMPLE_WIDTH-1:0]    wet_q;
	logic                       sign_q;
	logic                       byp_q;
	logic                       zero_q;
	logic                       rise_q;
	logic [NEG_W-1:0]           neg_q;
	logic [DIFF_W-1:0]          diff_q;
	logic [ENV_W-1:0]           delta_q;
	logic [SHN_W-1:0]           shn_q;
	logic [EXP_W-1:0]           exp_q;

	logic                       accept;
	logic                       out_free;
	logic                       nstart;
	logic [SAMPLE_WIDTH-1:0]    mag_in;
	logic [LEVEL_W-1:0]         lvl;
	logic [LEVEL_W-1:0]         lvl_f;
	logic signed [LVL_S_W-1:0]  level_s;
	logic signed [LVL_S_W-1:0]  diff_s;
	logic [ENV_W-1:0]           target;
	logic [ENV_W-1:0]           env_step;
	logic [ENV_W-1:0]           env_next;
	logic [ATT_W-1:0]           att;
	logic [MUL_PW-1:0]          wet_full;
	logic [SAMPLE_WIDTH-1:0]    r_mag;
	logic [SAMPLE_WIDTH-1:0]    r_out;

	ffc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (cfg_valid),
		.ready  (cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	ffc_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.mag    (mag_in),
		.res    (nres)
	);

	ffc_mul u_mul (
		.clk  (clk),
		.op   (mop),
		.prod (prod)
	);

	assign sample_stall = state_q != ST_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !res_valid_q || !result_stall;
	assign nstart       = accept && cfg.enable;
	assign mag_in       = sample.sample_in[SAMPLE_WIDTH-1] ?
		(~sample.sample_in + SAMPLE_WIDTH'(1)) : sample.sample_in;

	assign lvl      = prod[32 +: LEVEL_W];
	assign lvl_f    = (zero_q || lvl > LEVEL_FLOOR) ? LEVEL_FLOOR : lvl;
	assign level_s  = -$signed({2'b00, lvl_f});
	assign diff_s   = level_s -
		$signed({{(LVL_S_W - THR_W){cfg.threshold_db[THR_W-1]}}, cfg.threshold_db});
	assign target   = prod[8 +: ENV_W];
	assign env_step = prod[16 +: ENV_W];
	assign env_next = rise_q ? (env_q + env_step) : (env_q - env_step);
	assign att      = prod[32 +: ATT_W];
	assign wet_full = prod >> (SH_BASE + 5'(shn_q));
	assign r_mag    = prod[16 +: SAMPLE_WIDTH];
	assign r_out    = sign_q ? (~r_mag + SAMPLE_WIDTH'(1)) : r_mag;

	always_comb begin
		mop = '0;
		unique case (state_q)
			ST_LVL: begin
				mop.en     = 1'b1;
				mop.a      = MUL_AW'(neg_q);
				mop.b      = MUL_BW'(DB256_PER_OCT);
				mop.addend = ROUND_LEVEL;
			end
			ST_TGT: begin
				mop.en = 1'b1;
				mop.a  = MUL_AW'(diff_q);
				mop.b  = MUL_BW'(cfg.ratio_slope);
			end
			ST_ENV: begin
				mop.en     = 1'b1;
				mop.a      = MUL_AW'(delta_q);
				mop.b      = MUL_BW'(rise_q ? cfg.attack_coeff : cfg.release_coeff);
				mop.addend = ROUND_Q16;
			end
			ST_ATT: begin
				mop.en = 1'b1;
				mop.a  = MUL_AW'(env_q);
				mop.b  = OCT_PER_DB;
			end
			ST_WET: begin
				mop.en     = 1'b1;
				mop.a      = MUL_AW'(mag_q);
				mop.b      = MUL_BW'(exp_q);
				mop.addend = MUL_PW'(1) << (SH_BASE - 5'd1 + 5'(shn_q));
			end
			ST_WSH: begin
				mop.en     = 1'b1;
				mop.a      = MUL_AW'(mag_q);
				mop.b      = MUL_BW'(COEF_ONE - cfg.mix_amount);
				mop.addend = ROUND_Q16;
			end
			ST_MIXW: begin
				mop.en  = 1'b1;
				mop.acc = 1'b1;
				mop.a   = MUL_AW'(wet_q);
				mop.b   = MUL_BW'(cfg.mix_amount);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			env_q       <= '0;
		end else begin
			res_valid_q <= (res_valid_q && result_stall) || (state_q == ST_FIN && out_free);
			unique case (state_q)
				ST_IDLE: if (accept) begin
					if (sample.clear_envelope) begin
						env_q <= '0;
					end
					state_q <= cfg.enable ? ST_NORM : ST_FIN;
				end
				ST_NORM: if (nres.done) begin
					state_q <= ST_NEG;
				end
				ST_NEG:   state_q <= ST_LVL;
				ST_LVL:   state_q <= ST_LEVEL;
				ST_LEVEL: state_q <= ST_TGT;
				ST_TGT:   state_q <= ST_CMP;
				ST_CMP:   state_q <= ST_ENV;
				ST_ENV:   state_q <= ST_UPD;
				ST_UPD: begin
					env_q   <= env_next;
					state_q <= ST_ATT;
				end
				ST_ATT:   state_q <= ST_EXP;
				ST_EXP:   state_q <= ST_WET;
				ST_WET:   state_q <= ST_WSH;
				ST_WSH:   state_q <= ST_MIXW;
				ST_MIXW:  state_q <= ST_FIN;
				ST_FIN: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				sample_q <= sample.sample_in;
				sign_q   <= sample.sample_in[SAMPLE_WIDTH-1];
				mag_q    <= mag_in;
				byp_q    <= !cfg.enable;
			end
			ST_NEG: begin
				neg_q  <= {nres.lz, 16'b0} - NEG_W'(LOG_ROM[nres.idx]);
				zero_q <= nres.zero;
			end
			ST_LEVEL: begin
				diff_q <= (diff_s > 0) ? diff_s[DIFF_W-1:0] : '0;
			end
			ST_CMP: begin
				rise_q  <= target > env_q;
				delta_q <= (target > env_q) ? (target - env_q) : (env_q - target);
			end
			ST_EXP: begin
				shn_q <= att[ATT_W-1 -: SHN_W];
				exp_q <= EXP_ROM[att[15 -: DB_BITS]];
			end
			ST_WSH: begin
				wet_q <= wet_full[SAMPLE_WIDTH-1:0];
			end
			ST_FIN: if (out_free) begin
				res_q.sample_out        <= byp_q ? sample_q : r_out;
				res_q.gain_reduction_db <= env_q[ENV_W-1 -: GR_W];
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_MAX)
		else $error("Envelope exceeds the largest reachable gain reduction.");

	a_fin_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (res_valid_q && state_q == ST_IDLE))
		else $error("Finished result was not loaded into the output register.");

	a_wet_le_dry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIXW) |-> (wet_q <= mag_q))
		else $error("Wet magnitude exceeds the dry magnitude.");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEG) |-> nres.done)
		else $error("Table lookup started before normalization finished.");

endmodule
